[rtl/msc_pkg.sv]
// Shared types, constants and register codes for the magnetometer correction block.
`default_nettype none

package msc_pkg;

  localparam int SAMPLE_W_DEF  = 16;
  localparam int COEF_FRAC_DEF = 14;
  localparam int WORD_W        = 16;
  localparam int AXES          = 3;
  localparam int REG_W         = 48;
  localparam int CFG_INDEX_W   = 3;

  localparam logic [REG_W-1:0] ROT_ROW0_RESET    = 48'h0000_0000_4000;
  localparam logic [REG_W-1:0] ROT_ROW1_RESET    = 48'h0000_4000_0000;
  localparam logic [REG_W-1:0] ROT_ROW2_RESET    = 48'h4000_0000_0000;
  localparam logic [REG_W-1:0] AXIS_SCALE_RESET  = 48'h4000_4000_4000;
  localparam logic [REG_W-1:0] AXIS_OFFSET_RESET = 48'h0000_0000_0000;
  localparam logic             FULL_MODE_RESET   = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROT_ROW0    = 3'd0,
    REG_ROT_ROW1    = 3'd1,
    REG_ROT_ROW2    = 3'd2,
    REG_AXIS_SCALE  = 3'd3,
    REG_AXIS_OFFSET = 3'd4,
    REG_FULL_MODE   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               clipped;
  } result_t;

  typedef struct packed {
    logic prod_en;
    logic sum_en;
  } lane_ctl_t;

endpackage

`default_nettype wire

[rtl/msc_lane.sv]
// One lane: dot product of a short vector with Q coefficients, rounded and saturated.
`default_nettype none

module msc_lane
  import msc_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_W_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF,
  parameter int TERMS          = AXES
) (
  input  logic                           clk,
  input  lane_ctl_t                      ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] vec  [TERMS],
  input  logic signed [WORD_W-1:0]       coef [TERMS],
  output logic signed [SAMPLE_WIDTH-1:0] res,
  output logic                           clip
);

  localparam int PW = SAMPLE_WIDTH + WORD_W;
  localparam int AW = PW + $clog2(TERMS) + 1;
  localparam logic signed [AW-1:0] HALF = AW'(1) << (COEF_FRAC_BITS - 1);

  logic signed [PW-1:0]           prod [TERMS];
  logic signed [AW-1:0]           acc;
  logic signed [AW-1:0]           shifted;
  logic                           ovf;
  logic signed [SAMPLE_WIDTH-1:0] sat_val;

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      for (int t = 0; t < TERMS; t++) begin
        prod[t] <= PW'(vec[t]) * PW'(coef[t]);
      end
    end
  end

  always_comb begin
    acc = HALF;
    for (int t = 0; t < TERMS; t++) begin
      acc = acc + AW'(prod[t]);
    end
    shifted = acc >>> COEF_FRAC_BITS;
    ovf = !((&shifted[AW-1:SAMPLE_WIDTH-1]) || !(|shifted[AW-1:SAMPLE_WIDTH-1]));
    if (ovf) begin
      sat_val = shifted[AW-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                              : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else begin
      sat_val = shifted[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      res  <= sat_val;
      clip <= ovf;
    end
  end

endmodule

`default_nettype wire

[rtl/magnetometer_softiron_correct_top.sv]
// Top level: config registers, offset stage, three lane groups and output merge.
//
//  channel  | signals                              | word
//  ---------+--------------------------------------+---------------------------
//  sample   | sample_valid, sample_ready, sample   | mag_x, mag_y, mag_z
//  result   | result_valid, result_ready, result   | out_x, out_y, out_z, clipped
//  cfg      | cfg_valid, cfg_ready, cfg_index/data | register write, always ready
//
// One sample per cycle sustained while result_ready holds; one register per stage:
// offset, rotate multiply, rotate sum, scale multiply, scale sum, back-rotate
// multiply, back-rotate sum into the output register.
// Each stage loads when it is empty or the next stage moves, so bubbles collapse
// and a stalled result still lets samples in until the pipe is full.
// Reset clears the stage valids and loads the register defaults.
`default_nettype none

module magnetometer_softiron_correct_top
  import msc_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = SAMPLE_W_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  sample_t                sample,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int XW     = SW + 17;
  localparam int STAGES = 7;
  localparam int ST_DIFF    = 0;
  localparam int ST_ROT_MUL = 1;
  localparam int ST_ROT     = 2;
  localparam int ST_SCL_MUL = 3;
  localparam int ST_SCL     = 4;
  localparam int ST_BK_MUL  = 5;
  localparam int ST_OUT     = 6;

  // configuration
  logic [REG_W-1:0] rot_row [AXES];
  logic [REG_W-1:0] axis_scale;
  logic [REG_W-1:0] axis_offset;
  logic             full_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row[0]  <= ROT_ROW0_RESET;
      rot_row[1]  <= ROT_ROW1_RESET;
      rot_row[2]  <= ROT_ROW2_RESET;
      axis_scale  <= AXIS_SCALE_RESET;
      axis_offset <= AXIS_OFFSET_RESET;
      full_mode   <= FULL_MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROT_ROW0:    rot_row[0]  <= cfg_data;
        REG_ROT_ROW1:    rot_row[1]  <= cfg_data;
        REG_ROT_ROW2:    rot_row[2]  <= cfg_data;
        REG_AXIS_SCALE:  axis_scale  <= cfg_data;
        REG_AXIS_OFFSET: axis_offset <= cfg_data;
        REG_FULL_MODE:   full_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage control
  logic [STAGES:0]   rdy;
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] vld_next;

  always_comb begin
    rdy[STAGES] = result_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    vld_next = {vld[STAGES-2:0], sample_valid};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_next[k];
        end
      end
    end
  end

  assign sample_ready = rdy[0];
  assign result_valid = vld[ST_OUT];

  // coefficient unpacking
  logic signed [WORD_W-1:0] rm       [AXES][AXES];
  logic signed [WORD_W-1:0] bk_coef  [AXES][AXES];
  logic signed [WORD_W-1:0] scl_coef [AXES][1];
  logic signed [WORD_W-1:0] off_w    [AXES];
  logic signed [WORD_W-1:0] mag      [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      for (int j = 0; j < AXES; j++) begin
        rm[i][j]      = rot_row[i][WORD_W*j +: WORD_W];
        bk_coef[j][i] = rot_row[i][WORD_W*j +: WORD_W];
      end
      scl_coef[i][0] = axis_scale[WORD_W*i +: WORD_W];
      off_w[i]       = axis_offset[WORD_W*i +: WORD_W];
    end
    mag[0] = sample.mag_x;
    mag[1] = sample.mag_y;
    mag[2] = sample.mag_z;
  end

  // offset stage
  logic signed [16:0]    diff   [AXES];
  logic signed [XW-1:0]  diff_x [AXES];
  logic signed [SW-1:0]  d_next [AXES];
  logic [AXES-1:0]       d_ovf;
  logic signed [SW-1:0]  d      [AXES];
  logic [STAGES-1:0]     clip_q;
  logic [STAGES-2:0]     clip_add;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      diff[a]   = {mag[a][15], mag[a]} - {off_w[a][15], off_w[a]};
      diff_x[a] = {{SW{diff[a][16]}}, diff[a]};
      d_ovf[a]  = !((&diff_x[a][XW-1:SW-1]) || !(|diff_x[a][XW-1:SW-1]));
      if (d_ovf[a]) begin
        d_next[a] = diff_x[a][XW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
        d_next[a] = diff_x[a][SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_DIFF]) begin
      d <= d_next;
    end
  end

  // lanes
  logic signed [SW-1:0] p       [AXES];
  logic signed [SW-1:0] s       [AXES];
  logic signed [SW-1:0] bk_res  [AXES];
  logic signed [SW-1:0] scl_vec [AXES][1];
  logic [AXES-1:0]      rot_clip;
  logic [AXES-1:0]      scl_clip;
  logic [AXES-1:0]      bk_clip;
  lane_ctl_t            rot_ctl;
  lane_ctl_t            scl_ctl;
  lane_ctl_t            bk_ctl;

  assign rot_ctl = '{prod_en: rdy[ST_ROT_MUL], sum_en: rdy[ST_ROT]};
  assign scl_ctl = '{prod_en: rdy[ST_SCL_MUL], sum_en: rdy[ST_SCL]};
  assign bk_ctl  = '{prod_en: rdy[ST_BK_MUL],  sum_en: rdy[ST_OUT]};

  for (genvar i = 0; i < AXES; i++) begin : g_lanes
    assign scl_vec[i][0] = p[i];

    msc_lane #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS), .TERMS(AXES)
    ) u_rot (
      .clk(clk), .ctl(rot_ctl), .vec(d), .coef(rm[i]), .res(p[i]), .clip(rot_clip[i])
    );

    msc_lane #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS), .TERMS(1)
    ) u_scl (
      .clk(clk), .ctl(scl_ctl), .vec(scl_vec[i]), .coef(scl_coef[i]), .res(s[i]),
      .clip(scl_clip[i])
    );

    msc_lane #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS), .TERMS(AXES)
    ) u_bk (
      .clk(clk), .ctl(bk_ctl), .vec(s), .coef(bk_coef[i]), .res(bk_res[i]),
      .clip(bk_clip[i])
    );
  end

  // clip flag and partial result follow the lanes
  logic signed [SW-1:0] p_pipe [ST_OUT-ST_ROT][AXES];

  always_comb begin
    clip_add = '0;
    clip_add[ST_ROT] = |rot_clip;
    clip_add[ST_SCL] = full_mode && (|scl_clip);
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_DIFF]) begin
      clip_q[ST_DIFF] <= |d_ovf;
    end
    for (int k = 1; k < STAGES; k++) begin
      if (rdy[k]) begin
        clip_q[k] <= clip_q[k-1] | clip_add[k-1];
      end
    end
    if (rdy[ST_SCL_MUL]) begin
      p_pipe[0] <= p;
    end
    for (int k = 1; k < ST_OUT - ST_ROT; k++) begin
      if (rdy[ST_ROT + 1 + k]) begin
        p_pipe[k] <= p_pipe[k-1];
      end
    end
  end

  // output merge
  logic signed [SW-1:0]    res_sel  [AXES];
  logic signed [SW+15:0]   res_wide [AXES];
  logic signed [15:0]      res16    [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      res_sel[a]  = full_mode ? bk_res[a] : p_pipe[ST_OUT-ST_ROT-1][a];
      res_wide[a] = (SW+16)'(res_sel[a]);
      res16[a]    = res_wide[a][15:0];
    end
    result.out_x   = res16[0];
    result.out_y   = res16[1];
    result.out_z   = res16[2];
    result.clipped = clip_q[ST_OUT] | (full_mode && (|bk_clip));
  end

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");
  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> sample_ready)
    else $error("sample refused with free output stage");
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> vld[ST_DIFF])
    else $error("accepted word did not enter offset stage");
  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    vld[ST_BK_MUL] && !rdy[ST_OUT] |=> vld[ST_BK_MUL] && vld[ST_OUT])
    else $error("stalled word lost in pipe");
`endif

endmodule

`default_nettype wire
